@@ rtl/fpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// fpp_pkg
// Shared constants, codes and types of the FEN piece-placement parser.
//------------------------------------------------------------------------------
package fpp_pkg;

	// ASCII characters the parser recognizes.
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
	localparam logic [7:0] CHAR_B     = 8'h62;
	localparam logic [7:0] CHAR_K     = 8'h6B;
	localparam logic [7:0] CHAR_N     = 8'h6E;
	localparam logic [7:0] CHAR_P     = 8'h70;
	localparam logic [7:0] CHAR_Q     = 8'h71;
	localparam logic [7:0] CHAR_R     = 8'h72;
	localparam logic [7:0] CHAR_W     = 8'h77;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// Result status codes.
	localparam logic [1:0] ST_CONSUMED = 2'd0;
	localparam logic [1:0] ST_PLACED   = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;
	localparam logic [1:0] ST_ERROR    = 2'd3;

	// Piece kinds.
	localparam logic [2:0] KIND_PAWN   = 3'd0;
	localparam logic [2:0] KIND_KNIGHT = 3'd1;
	localparam logic [2:0] KIND_BISHOP = 3'd2;
	localparam logic [2:0] KIND_ROOK   = 3'd3;
	localparam logic [2:0] KIND_QUEEN  = 3'd4;
	localparam logic [2:0] KIND_KING   = 3'd5;

	// Board geometry and counters.
	localparam logic [2:0] RANK_TOP       = 3'd7;
	localparam logic [2:0] RANK_BOTTOM    = 3'd0;
	localparam logic [4:0] FILES_PER_RANK = 5'd8;
	localparam logic [7:0] POS_SATURATE   = 8'hFF;

	typedef enum logic [5:0] {
		PH_BODY  = 6'b000001,
		PH_SLASH = 6'b000010,
		PH_SKIP  = 6'b000100,
		PH_SIDE  = 6'b001000,
		PH_DONE  = 6'b010000,
		PH_ERROR = 6'b100000
	} phase_t;

	// Character class, decoded ahead of the input register.
	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       is_piece;
		logic [2:0] kind;
		logic       black;
		logic       is_slash;
		logic       is_white_side;
		logic       is_black_side;
		logic       record_start;
	} char_info_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] square;
		logic [2:0] piece_kind;
		logic       black_piece;
		logic       black_to_move;
		logic [7:0] char_position;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/fpp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// fpp_if
// Valid/ready channels of the parser: record characters in, results out.
//------------------------------------------------------------------------------
interface fpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       record_start;

	modport source (output valid, output char_code, output record_start, input ready);
	modport sink   (input valid, input char_code, input record_start, output ready);
endinterface

interface fpp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] square;
	logic [2:0] piece_kind;
	logic       black_piece;
	logic       black_to_move;
	logic [7:0] char_position;

	modport source (output valid, output status, output square, output piece_kind,
		output black_piece, output black_to_move, output char_position, input ready);
	modport sink   (input valid, input status, input square, input piece_kind,
		input black_piece, input black_to_move, input char_position, output ready);
endinterface
`default_nettype wire

@@ rtl/fpp_char_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// fpp_char_decode
// Classifies one record character: digit, piece letter, slash or side letter.
//------------------------------------------------------------------------------
module fpp_char_decode (
	input  wire logic [7:0]          char_code,
	input  wire logic                record_start,
	output fpp_pkg::char_info_t      info
);
	import fpp_pkg::*;

	logic [7:0] lower_code;
	logic [7:0] digit_full;
	logic       is_letter;

	always_comb begin
		lower_code = char_code | CASE_BIT;
		digit_full = char_code - CHAR_ZERO;
		// Folding the case bit maps exactly the upper and lower letters into a..z.
		is_letter  = (lower_code >= CHAR_LC_A) && (lower_code <= CHAR_LC_Z);

		info = '0;
		info.record_start  = record_start;
		info.is_digit      = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		info.digit         = digit_full[3:0];
		info.is_slash      = (char_code == CHAR_SLASH);
		info.is_white_side = (char_code == CHAR_W);
		info.is_black_side = (char_code == CHAR_B);
		info.black         = (char_code & CASE_BIT) != 8'h00;
		info.is_piece      = 1'b0;
		info.kind          = KIND_PAWN;
		if (is_letter) begin
			case (lower_code)
				CHAR_P: begin info.is_piece = 1'b1; info.kind = KIND_PAWN;   end
				CHAR_N: begin info.is_piece = 1'b1; info.kind = KIND_KNIGHT; end
				CHAR_B: begin info.is_piece = 1'b1; info.kind = KIND_BISHOP; end
				CHAR_R: begin info.is_piece = 1'b1; info.kind = KIND_ROOK;   end
				CHAR_Q: begin info.is_piece = 1'b1; info.kind = KIND_QUEEN;  end
				CHAR_K: begin info.is_piece = 1'b1; info.kind = KIND_KING;   end
				default: begin info.is_piece = 1'b0; info.kind = KIND_PAWN; end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/fpp_parse_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// fpp_parse_step
// Parser state registers and the next-state and result logic for one character.
//------------------------------------------------------------------------------
module fpp_parse_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire fpp_pkg::char_info_t info,
	output fpp_pkg::result_t         result
);
	import fpp_pkg::*;

	phase_t     phase_q, phase_cur, phase_nxt;
	logic [2:0] rank_q, rank_cur, rank_nxt;
	logic [4:0] file_q, file_cur, file_nxt;
	logic [7:0] count_q, count_cur, count_nxt;
	logic       body_ok;

	always_comb begin
		// A record start restarts the parse with this character as the first one.
		phase_cur = info.record_start ? PH_BODY : phase_q;
		rank_cur  = info.record_start ? RANK_TOP : rank_q;
		file_cur  = info.record_start ? 5'd0 : file_q;
		count_cur = info.record_start ? 8'd0 : count_q;

		phase_nxt = phase_cur;
		rank_nxt  = rank_cur;
		file_nxt  = file_cur;
		body_ok   = 1'b0;

		result = '0;
		result.status        = ST_CONSUMED;
		result.char_position = count_cur;

		case (phase_cur)
			PH_BODY: begin
				if (info.is_digit) begin
					file_nxt = file_cur + {1'b0, info.digit};
					body_ok  = 1'b1;
				end else if (info.is_piece) begin
					result.status      = ST_PLACED;
					result.square      = {rank_cur, file_cur[2:0]};
					result.piece_kind  = info.kind;
					result.black_piece = info.black;
					file_nxt = file_cur + 5'd1;
					body_ok  = 1'b1;
				end else begin
					result.status = ST_ERROR;
					phase_nxt     = PH_ERROR;
				end
				if (body_ok && (file_nxt >= FILES_PER_RANK)) begin
					phase_nxt = (rank_cur != RANK_BOTTOM) ? PH_SLASH : PH_SKIP;
				end
			end
			PH_SLASH: begin
				if (info.is_slash) begin
					rank_nxt  = rank_cur - 3'd1;
					file_nxt  = 5'd0;
					phase_nxt = PH_BODY;
				end else begin
					result.status = ST_ERROR;
					phase_nxt     = PH_ERROR;
				end
			end
			PH_SKIP: begin
				phase_nxt = PH_SIDE;
			end
			PH_SIDE: begin
				if (info.is_white_side || info.is_black_side) begin
					result.status        = ST_COMPLETE;
					result.black_to_move = info.is_black_side;
					phase_nxt            = PH_DONE;
				end else begin
					result.status = ST_ERROR;
					phase_nxt     = PH_ERROR;
				end
			end
			default: begin
				phase_nxt = phase_cur;
			end
		endcase

		count_nxt = (count_cur != POS_SATURATE) ? count_cur + 8'd1 : count_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BODY;
			rank_q  <= RANK_TOP;
			file_q  <= 5'd0;
			count_q <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			rank_q  <= rank_nxt;
			file_q  <= file_nxt;
			count_q <= count_nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/fen_placement_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// fen_placement_parser_core
// Parses the piece-placement and side-to-move fields of a FEN record, one
// character per transfer, and returns one result per character.
//------------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_ch    sink       char_code[7:0], record_start
//  out_ch   source     status[1:0], square[5:0], piece_kind[2:0], black_piece,
//                      black_to_move, char_position[7:0]
//
// Each character passes from the input register to the result register, and one
// character is accepted every cycle while the output is not stalled; each character
// makes a single parse state update as it moves into the result register.
// Reset puts the parser at the first file of the top rank, as a record start does.
// A stalled output holds its result while the input stage still takes one more
// character; the input stalls only when both stages are full.
//------------------------------------------------------------------------------
module fen_placement_parser_core (
	input wire logic  clk,
	input wire logic  arst_n,
	fpp_in_if.sink    in_ch,
	fpp_out_if.source out_ch
);
	import fpp_pkg::*;

	char_info_t info_in;
	char_info_t info_s1;
	logic       valid_s1;
	logic       advance;
	result_t    result_nxt;
	result_t    result_q;
	logic       out_valid_q;

	// Character classification happens before the input register so that the
	// stage after it holds only the state update.
	fpp_char_decode u_decode (
		.char_code    (in_ch.char_code),
		.record_start (in_ch.record_start),
		.info         (info_in)
	);

	// The held character moves on whenever the result register is empty or its
	// result is being taken in this cycle.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			info_s1 <= info_in;
		end
	end

	// The parse state advances exactly once for each character that moves into
	// the result register, which keeps results in character order.
	fpp_parse_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.info    (info_s1),
		.result  (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = result_q.status;
	assign out_ch.square        = result_q.square;
	assign out_ch.piece_kind    = result_q.piece_kind;
	assign out_ch.black_piece   = result_q.black_piece;
	assign out_ch.black_to_move = result_q.black_to_move;
	assign out_ch.char_position = result_q.char_position;

endmodule
`default_nettype wire
